/* design/geo_route_request_rebroadcast_filter_core_macros.svh */
// Assertion macros shared by the rebroadcast filter design files.
`ifndef GEO_ROUTE_REQUEST_REBROADCAST_FILTER_CORE_MACROS_SVH
`define GEO_ROUTE_REQUEST_REBROADCAST_FILTER_CORE_MACROS_SVH

// Implication in the same cycle.
`define GRRF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the following cycle.
`define GRRF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

// Implication checked a fixed number of cycles later.
`define GRRF_ASSERT_DELAY(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error("assertion failed");

`endif

/* design/grrf_pkg.sv */
// Package with modes, control structs and the squared cosine table of the filter.
`default_nettype none
package grrf_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int C2_W = 61;
  localparam int HIDX_W = 8;

  localparam logic [2:0] MODE_REGULAR  = 3'd0;
  localparam logic [2:0] MODE_LAR_DIST = 3'd1;
  localparam logic [2:0] MODE_LAR_ZONE = 3'd2;
  localparam logic [2:0] MODE_GEO_STAT = 3'd3;
  localparam logic [2:0] MODE_GEO_EXP  = 3'd4;
  localparam logic [2:0] MODE_GEO_ROT  = 3'd5;
  localparam logic [2:0] MODE_ROT_HALF = 3'd6;

  typedef struct packed {
    logic              valid;
    logic [2:0]        mode;
    logic              bcast;
    logic              zone;
    logic              cneg;
    logic [HIDX_W-1:0] hidx;
  } grrf_geo_ctl_t;

  typedef struct packed {
    logic              valid;
    logic              use_geo;
    logic              early;
    logic              cneg;
    logic              dneg;
    logic [HIDX_W-1:0] hidx;
  } grrf_dec_t;

  typedef logic [C2_W-1:0] grrf_c2_tab_t [0:180];

  // Cosine of half the angle in Q30, by an eight term Horner series.
  // Every term is non-negative, so dropping the Q30 scale first and then
  // dividing by the small factor truncates exactly as one combined division.
  function automatic logic [63:0] cos_mag(int unsigned hh);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] one;
    one = 64'd1 << 30;
    if (hh == 180) begin
      return 64'd0;
    end
    x  = (64'(hh) * 64'd3373259426 + 64'd180) / 64'd360;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    t  = one;
    t  = one - ((x2 * t) >> 30) / 64'd182;
    t  = one - ((x2 * t) >> 30) / 64'd132;
    t  = one - ((x2 * t) >> 30) / 64'd90;
    t  = one - ((x2 * t) >> 30) / 64'd56;
    t  = one - ((x2 * t) >> 30) / 64'd30;
    t  = one - ((x2 * t) >> 30) / 64'd12;
    t  = one - ((x2 * t) >> 30) / 64'd2;
    return t;
  endfunction

  function automatic grrf_c2_tab_t build_c2();
    grrf_c2_tab_t r;
    logic [63:0] c;
    for (int h = 0; h <= 180; h++) begin
      c    = cos_mag(h);
      r[h] = C2_W'(c * c);
    end
    return r;
  endfunction

  localparam grrf_c2_tab_t C2_TAB = build_c2();

endpackage
`default_nettype wire

/* design/geo_route_request_rebroadcast_filter_core.sv */
// Top level of the route request rebroadcast filter: mode register, decision pipeline.
// An item taken at a clock edge gives its result strobe through the ctl1, ctl2, dec, ctl_q and done registers.
// Throughput: one item every cycle; busy_o never rises, as the pipeline cannot stall.
// The pipeline has eight register stages, the widest being those of the three chunked multipliers.
// Reset clears the valid bits of every stage and sets routing_mode to regular.
`default_nettype none
`include "geo_route_request_rebroadcast_filter_core_macros.svh"
module geo_route_request_rebroadcast_filter_core import grrf_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [2:0]                   cfg_wdata_i,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic signed [COORD_BITS-1:0] origin_x_i,
  input  wire logic signed [COORD_BITS-1:0] origin_y_i,
  input  wire logic signed [COORD_BITS-1:0] previous_x_i,
  input  wire logic signed [COORD_BITS-1:0] previous_y_i,
  input  wire logic signed [COORD_BITS-1:0] current_x_i,
  input  wire logic signed [COORD_BITS-1:0] current_y_i,
  input  wire logic signed [COORD_BITS-1:0] target_x_i,
  input  wire logic signed [COORD_BITS-1:0] target_y_i,
  input  wire logic [8:0]                   flood_angle_i,
  input  wire logic [14:0]                  target_speed_i,
  output logic                              done_o,
  output logic                              forward_request_o
);

  // Width of sums of two squared coordinate differences, sign included.
  localparam int SUM_W = 2 * (COORD_BITS + 1) + 1;
  localparam int P_W   = 2 * SUM_W;
  localparam int CW    = P_W + C2_W;
  localparam int LAT   = 8;

  logic [2:0] routing_mode_q;

  grrf_geo_ctl_t           gctl;
  logic [SUM_W-1:0]        la, lb, dp, dc;
  logic signed [SUM_W-1:0] dot;

  grrf_dec_t        dec_d, dec_q;
  grrf_dec_t        ctl_q [4];
  logic [SUM_W-1:0] la_q, lb_q, dmag_q;
  logic [P_W-1:0]   prod_len, prod_dot;
  logic [P_W-1:0]   l1_q, l2_q;
  logic [C2_W-1:0]  c2;
  logic [CW-1:0]    rhs, lhs;
  logic             geo_fwd, fwd_d;
  logic             done_q, fwd_q;

  // The user must write the mode register only while no item is in flight; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      routing_mode_q <= MODE_REGULAR;
    end else if (cfg_we_i) begin
      routing_mode_q <= cfg_wdata_i;
    end
  end

  assign busy_o = 1'b0;

  grrf_geom #(
    .COORD_BITS(COORD_BITS),
    .SUM_W     (SUM_W)
  ) u_geom (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (start_i),
    .mode_i        (routing_mode_q),
    .origin_x_i    (origin_x_i),
    .origin_y_i    (origin_y_i),
    .previous_x_i  (previous_x_i),
    .previous_y_i  (previous_y_i),
    .current_x_i   (current_x_i),
    .current_y_i   (current_y_i),
    .target_x_i    (target_x_i),
    .target_y_i    (target_y_i),
    .flood_angle_i (flood_angle_i),
    .target_speed_i(target_speed_i),
    .ctl_o         (gctl),
    .la_o          (la),
    .lb_o          (lb),
    .dot_o         (dot),
    .dp_o          (dp),
    .dc_o          (dc)
  );

  // Third stage: everything but the angle test is settled here. The angle test is
  // skipped for a plain broadcast angle and for a zero-length vector, both of which
  // forward the request.
  always_comb begin
    logic zero_len;
    logic is_geo;
    zero_len      = (la == '0) || (lb == '0);
    is_geo        = 1'b0;
    dec_d.valid   = gctl.valid;
    dec_d.cneg    = gctl.cneg;
    dec_d.hidx    = gctl.hidx;
    dec_d.dneg    = dot[SUM_W-1];
    dec_d.early   = 1'b1;
    case (gctl.mode)
      MODE_LAR_DIST: dec_d.early = (dp >= dc);
      MODE_LAR_ZONE: dec_d.early = gctl.zone;
      MODE_GEO_STAT, MODE_GEO_EXP, MODE_GEO_ROT, MODE_ROT_HALF: begin
        is_geo = !gctl.bcast && !zero_len;
      end
      default: dec_d.early = 1'b1;
    endcase
    dec_d.use_geo = is_geo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_q <= '0;
      for (int i = 0; i < 4; i++) begin
        ctl_q[i] <= '0;
      end
    end else begin
      dec_q    <= dec_d;
      ctl_q[0] <= dec_q;
      for (int i = 1; i < 4; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    la_q   <= la;
    lb_q   <= lb;
    dmag_q <= dot[SUM_W-1] ? SUM_W'(-dot) : SUM_W'(dot);
  end

  // Product of the two squared lengths, and the squared dot product.
  grrf_mul #(.A_W(SUM_W), .B_W(SUM_W)) u_mul_len (
    .clk_i(clk_i),
    .a_i  (la_q),
    .b_i  (lb_q),
    .p_o  (prod_len)
  );

  grrf_mul #(.A_W(SUM_W), .B_W(SUM_W)) u_mul_dot (
    .clk_i(clk_i),
    .a_i  (dmag_q),
    .b_i  (dmag_q),
    .p_o  (prod_dot)
  );

  // The squared cosine of half the limit comes from the constant table.
  assign c2 = C2_TAB[ctl_q[1].hidx];

  grrf_mul #(.A_W(C2_W), .B_W(P_W)) u_mul_cos (
    .clk_i(clk_i),
    .a_i  (c2),
    .b_i  (prod_len),
    .p_o  (rhs)
  );

  always_ff @(posedge clk_i) begin
    l1_q <= prod_dot;
    l2_q <= l1_q;
  end

  // The squared dot product is scaled by the square of one in Q30.
  assign lhs = CW'({l2_q, 60'd0});

  always_comb begin
    if (!ctl_q[3].cneg) begin
      geo_fwd = !ctl_q[3].dneg && (lhs >= rhs);
    end else begin
      geo_fwd = !ctl_q[3].dneg || (lhs <= rhs);
    end
    fwd_d = ctl_q[3].use_geo ? geo_fwd : ctl_q[3].early;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_q[3].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_q <= fwd_d;
  end

  assign done_o            = done_q;
  assign forward_request_o = fwd_q;

  `GRRF_ASSERT_DELAY(a_latency, start_i, 8, done_o)
  `GRRF_ASSERT_IMP(a_no_spurious, !$past(start_i, LAT), !done_o)
  `GRRF_ASSERT_NEXT(a_early_kept, ctl_q[3].valid && !ctl_q[3].use_geo, forward_request_o == $past(ctl_q[3].early))

endmodule
`default_nettype wire

/* design/grrf_mul.sv */
// Two stage unsigned multiplier built from registered 32 by 32 partial products.
`default_nettype none
module grrf_mul #(
  parameter int A_W = 35,
  parameter int B_W = 35
) (
  input  wire logic               clk_i,
  input  wire logic [A_W-1:0]     a_i,
  input  wire logic [B_W-1:0]     b_i,
  output logic [A_W+B_W-1:0]      p_o
);

  localparam int NA = (A_W + 31) / 32;
  localparam int NB = (B_W + 31) / 32;
  localparam int AW = (NA + NB) * 32;

  logic [NA*32-1:0] a_ext;
  logic [NB*32-1:0] b_ext;
  logic [63:0]      pp_q [NA*NB];
  logic [AW-1:0]    acc;
  logic [A_W+B_W-1:0] p_q;

  assign a_ext = (NA*32)'(a_i);
  assign b_ext = (NB*32)'(b_i);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_q[i*NB+j] <= 64'(a_ext[32*i +: 32]) * 64'(b_ext[32*j +: 32]);
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (AW'(pp_q[i*NB+j]) << (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= (A_W+B_W)'(acc);
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

/* design/grrf_geom.sv */
// Front stages: vector differences, zone test, then squared lengths and dot product.
`default_nettype none
module grrf_geom import grrf_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int SUM_W = 2 * (COORD_BITS + 1) + 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  input  wire logic [2:0]                   mode_i,
  input  wire logic signed [COORD_BITS-1:0] origin_x_i,
  input  wire logic signed [COORD_BITS-1:0] origin_y_i,
  input  wire logic signed [COORD_BITS-1:0] previous_x_i,
  input  wire logic signed [COORD_BITS-1:0] previous_y_i,
  input  wire logic signed [COORD_BITS-1:0] current_x_i,
  input  wire logic signed [COORD_BITS-1:0] current_y_i,
  input  wire logic signed [COORD_BITS-1:0] target_x_i,
  input  wire logic signed [COORD_BITS-1:0] target_y_i,
  input  wire logic [8:0]                   flood_angle_i,
  input  wire logic [14:0]                  target_speed_i,
  output grrf_geo_ctl_t                     ctl_o,
  output logic [SUM_W-1:0]                  la_o,
  output logic [SUM_W-1:0]                  lb_o,
  output logic signed [SUM_W-1:0]           dot_o,
  output logic [SUM_W-1:0]                  dp_o,
  output logic [SUM_W-1:0]                  dc_o
);

  localparam int D  = COORD_BITS + 1;
  localparam int ZW = ((COORD_BITS > 15) ? COORD_BITS : 15) + 2;

  logic signed [COORD_BITS-1:0] ax, ay;
  logic signed [D-1:0] dx_d, dy_d, cx_d, cy_d, ex_d, ey_d, fx_d, fy_d;
  logic signed [D-1:0] dx_q, dy_q, cx_q, cy_q, ex_q, ey_q, fx_q, fy_q;
  logic signed [ZW-1:0] oxz, oyz, txz, tyz, cxz, cyz, spz;
  logic signed [ZW-1:0] lox, hix, loy, hiy;
  logic [8:0] h9;
  grrf_geo_ctl_t ctl1_d, ctl1_q, ctl2_q;

  logic signed [2*D-1:0] pdd, pdd2, pcc, pcc2, pdc, pdc2, pee, pee2, pff, pff2;
  logic [SUM_W-1:0] la_q, lb_q, dp_q, dc_q;
  logic signed [SUM_W-1:0] dot_q;

  // The geo modes other than the static and expanding ones measure from the previous node.
  always_comb begin
    if (mode_i == MODE_GEO_ROT || mode_i == MODE_ROT_HALF) begin
      ax = previous_x_i;
      ay = previous_y_i;
    end else begin
      ax = origin_x_i;
      ay = origin_y_i;
    end
  end

  assign dx_d = D'(target_x_i) - D'(ax);
  assign dy_d = D'(target_y_i) - D'(ay);
  assign cx_d = D'(current_x_i) - D'(ax);
  assign cy_d = D'(current_y_i) - D'(ay);
  assign ex_d = D'(previous_x_i) - D'(target_x_i);
  assign ey_d = D'(previous_y_i) - D'(target_y_i);
  assign fx_d = D'(current_x_i) - D'(target_x_i);
  assign fy_d = D'(current_y_i) - D'(target_y_i);

  assign oxz = ZW'(origin_x_i);
  assign oyz = ZW'(origin_y_i);
  assign txz = ZW'(target_x_i);
  assign tyz = ZW'(target_y_i);
  assign cxz = ZW'(current_x_i);
  assign cyz = ZW'(current_y_i);
  assign spz = ZW'($signed({1'b0, target_speed_i}));

  always_comb begin
    lox = (oxz < txz - spz) ? oxz : txz - spz;
    hix = (oxz > txz + spz) ? oxz : txz + spz;
    loy = (oyz < tyz - spz) ? oyz : tyz - spz;
    hiy = (oyz > tyz + spz) ? oyz : tyz + spz;
    h9  = (mode_i == MODE_ROT_HALF) ? 9'd180 : flood_angle_i;
    ctl1_d.valid = valid_i;
    ctl1_d.mode  = mode_i;
    ctl1_d.bcast = (flood_angle_i >= 9'd360);
    ctl1_d.zone  = (cxz >= lox) && (cxz <= hix) && (cyz >= loy) && (cyz <= hiy);
    ctl1_d.cneg  = (h9 > 9'd180);
    ctl1_d.hidx  = (h9 > 9'd180) ? HIDX_W'(9'd360 - h9) : HIDX_W'(h9);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else begin
      ctl1_q <= ctl1_d;
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q <= dx_d;
    dy_q <= dy_d;
    cx_q <= cx_d;
    cy_q <= cy_d;
    ex_q <= ex_d;
    ey_q <= ey_d;
    fx_q <= fx_d;
    fy_q <= fy_d;
  end

  assign pdd  = dx_q * dx_q;
  assign pdd2 = dy_q * dy_q;
  assign pcc  = cx_q * cx_q;
  assign pcc2 = cy_q * cy_q;
  assign pdc  = dx_q * cx_q;
  assign pdc2 = dy_q * cy_q;
  assign pee  = ex_q * ex_q;
  assign pee2 = ey_q * ey_q;
  assign pff  = fx_q * fx_q;
  assign pff2 = fy_q * fy_q;

  always_ff @(posedge clk_i) begin
    la_q  <= SUM_W'(pdd) + SUM_W'(pdd2);
    lb_q  <= SUM_W'(pcc) + SUM_W'(pcc2);
    dot_q <= SUM_W'(pdc) + SUM_W'(pdc2);
    dp_q  <= SUM_W'(pee) + SUM_W'(pee2);
    dc_q  <= SUM_W'(pff) + SUM_W'(pff2);
  end

  assign ctl_o = ctl2_q;
  assign la_o  = la_q;
  assign lb_o  = lb_q;
  assign dot_o = dot_q;
  assign dp_o  = dp_q;
  assign dc_o  = dc_q;

endmodule
`default_nettype wire
